// File: hw/rtl/box_blur_3x3_unit_defines.svh
// ----------------------------------------------------------------------------
// Box blur 3x3 assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBX_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBX_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bbx_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Widths, register indexes, job and status types, and the reciprocal table.
// ----------------------------------------------------------------------------
package bbx_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int SLOT_W     = $clog2(MAX_WIDTH);
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int SUM_W   = 12;
  localparam int CNT_W   = 4;
  localparam int NUM_W   = SUM_W + 1;
  localparam int RECIP_K = 20;
  localparam int RECIP_W = 20;
  localparam int PROD_W  = NUM_W + RECIP_W;

  localparam int JOB_DEPTH = 2;
  localparam int QPTR_W    = $clog2(JOB_DEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  // Result kinds: upper row with centre column c-1, upper row at row end,
  // last row with centre column c-1, last row at row end.
  localparam int KIND_UP_MID  = 0;
  localparam int KIND_UP_END  = 1;
  localparam int KIND_LOW_MID = 2;
  localparam int KIND_LOW_END = 3;
  localparam int NUM_KINDS    = 4;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [NUM_KINDS-1:0]  kinds;
    logic                  row_ge2;
    logic                  row_ge1;
    logic                  col_ge2;
    logic                  col_ge1;
  } bbx_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bbx_qstat_t;

  // Reciprocal of twice the pixel count, scaled by 2**RECIP_K and rounded up.
  function automatic logic [RECIP_W-1:0] bbx_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      CNT_W'(1): m = RECIP_W'(524288);
      CNT_W'(2): m = RECIP_W'(262144);
      CNT_W'(3): m = RECIP_W'(174763);
      CNT_W'(4): m = RECIP_W'(131072);
      CNT_W'(6): m = RECIP_W'(87382);
      CNT_W'(9): m = RECIP_W'(58255);
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/bbx_if.sv
// ----------------------------------------------------------------------------
// Box blur channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bbx_in_if import bbx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface bbx_out_if import bbx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            run_last;
  logic            frame_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output run_last, output frame_done, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input run_last, input frame_done, output ready);
endinterface

interface bbx_cfg_if import bbx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/bbx_front.sv
// ----------------------------------------------------------------------------
// Box blur front end
// Accepts pixels, keeps the row stores and the window, and queues result jobs.
// ----------------------------------------------------------------------------
module bbx_front import bbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbx_cfg_if.sink    cfg_i,
  bbx_in_if.sink     in_i,
  input  bbx_qstat_t qstat_i,
  output logic       push_o,
  output bbx_job_t   job_o
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PUSH = 2'b10
  } bbx_front_state_e;

  bbx_front_state_e      state_q, state_d;
  logic [FW_W-1:0]       fw_q;
  logic [FH_W-1:0]       fh_q;
  logic [SLOT_W-1:0]     col_q;
  logic [FH_W-1:0]       row_q;
  logic [8:0][PIX_W-1:0] win_q;
  logic [8:0][PIX_W-1:0] win_d;
  logic [PIX_W-1:0]      pix_q;
  logic [2*PIX_W-1:0]    row_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]    rd_q;

  logic [FW_W-1:0] w_eff;
  logic [FH_W:0]   h_eff;
  logic            accept;
  logic            cfg_wr;
  logic            row_end;
  logic            last_row;
  logic            advance;
  logic [NUM_KINDS-1:0] kinds;

  assign in_i.ready  = (state_q == F_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_wr      = cfg_i.valid && ((cfg_i.index == CFG_FRAME_WIDTH) ||
                                       (cfg_i.index == CFG_FRAME_HEIGHT));

  always_comb begin
    priority if (fw_q == '0) begin
      w_eff = FW_W'(1);
    end else if (fw_q > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    h_eff = (fh_q == '0) ? (FH_W + 1)'(1) : {1'b0, fh_q};
  end

  assign row_end  = ((FW_W'(col_q) + FW_W'(1)) >= w_eff);
  assign last_row = (({1'b0, row_q} + (FH_W + 1)'(1)) >= h_eff);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i]     = win_q[3 + i];
      win_d[3 + i] = win_q[6 + i];
    end
    win_d[6] = rd_q[2*PIX_W-1:PIX_W];
    win_d[7] = rd_q[PIX_W-1:0];
    win_d[8] = pix_q;
  end

  always_comb begin
    kinds[KIND_UP_MID]  = (row_q != '0) && (col_q != '0);
    kinds[KIND_UP_END]  = (row_q != '0) && row_end;
    kinds[KIND_LOW_MID] = last_row && (col_q != '0);
    kinds[KIND_LOW_END] = last_row && row_end;
  end

  assign advance = (state_q == F_PUSH) && ((kinds == '0) || !qstat_i.full);
  assign push_o  = advance && (kinds != '0);

  always_comb begin
    job_o.win     = win_d;
    job_o.kinds   = kinds;
    job_o.row_ge2 = (row_q >= FH_W'(2));
    job_o.row_ge1 = (row_q != '0);
    job_o.col_ge2 = (col_q >= SLOT_W'(2));
    job_o.col_ge1 = (col_q != '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (advance) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= row_mem[col_q];
      pix_q <= {in_i.blue_in, in_i.green_in, in_i.red_in};
    end
    if (advance) begin
      row_mem[col_q] <= {rd_q[PIX_W-1:0], pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      fw_q    <= FW_W'(MAX_WIDTH);
      fh_q    <= FH_W'(768);
      col_q   <= '0;
      row_q   <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (cfg_i.index == CFG_FRAME_WIDTH) begin
          fw_q <= cfg_i.data[FW_W-1:0];
        end else begin
          fh_q <= cfg_i.data[FH_W-1:0];
        end
        col_q <= '0;
        row_q <= '0;
        win_q <= '0;
      end else if (advance) begin
        win_q <= win_d;
        if (row_end) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + FH_W'(1);
        end else begin
          col_q <= col_q + SLOT_W'(1);
        end
      end
    end
  end

endmodule

// File: hw/rtl/bbx_job_queue.sv
// ----------------------------------------------------------------------------
// Box blur job queue
// Short first-in first-out queue of result jobs between front and back end.
// ----------------------------------------------------------------------------
module bbx_job_queue import bbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bbx_job_t   job_i,
  input  logic       pop_i,
  output bbx_job_t   job_o,
  output bbx_qstat_t qstat_o
);

  bbx_job_t          entry_q [JOB_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign qstat_o.full  = (cnt_q == QCNT_W'(JOB_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign job_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/bbx_back.sv
// ----------------------------------------------------------------------------
// Box blur back end
// Expands each job into its results: window sum, rounded division, output.
// ----------------------------------------------------------------------------
module bbx_back import bbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bbx_job_t   job_i,
  input  bbx_qstat_t qstat_i,
  output logic       pop_o,
  bbx_out_if.source  out_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SUM  = 4'b0010,
    B_MUL  = 4'b0100,
    B_EMIT = 4'b1000
  } bbx_back_state_e;

  bbx_back_state_e          state_q, state_d;
  bbx_job_t                 job_q;
  logic [NUM_KINDS-1:0]     pend_q;
  logic [2:0][SUM_W-1:0]    sum_q;
  logic [2:0][SUM_W-1:0]    sum_d;
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         cnt_d;
  logic                     last_q;
  logic                     done_q;
  logic [2:0][PROD_W-1:0]   prod_q;
  logic                     ovalid_q;
  logic [2:0][CH_W-1:0]     oval_q;
  logic                     olast_q;
  logic                     odone_q;

  logic [NUM_KINDS-1:0] sel;
  logic [2:0]           rows;
  logic [2:0]           cols;
  logic                 out_free;
  logic [2:0][CH_W-1:0] quot;

  assign out_free = !ovalid_q || out_o.ready;
  assign pop_o    = (state_q == B_IDLE) && !qstat_i.empty;

  always_comb begin
    sel = '0;
    priority if (pend_q[KIND_UP_MID]) begin
      sel[KIND_UP_MID] = 1'b1;
    end else if (pend_q[KIND_UP_END]) begin
      sel[KIND_UP_END] = 1'b1;
    end else if (pend_q[KIND_LOW_MID]) begin
      sel[KIND_LOW_MID] = 1'b1;
    end else begin
      sel[KIND_LOW_END] = 1'b1;
    end
  end

  always_comb begin
    if (sel[KIND_UP_MID] || sel[KIND_UP_END]) begin
      rows = {1'b1, 1'b1, job_q.row_ge2};
    end else begin
      rows = {1'b1, job_q.row_ge1, 1'b0};
    end
    if (sel[KIND_UP_END] || sel[KIND_LOW_END]) begin
      cols = {1'b1, job_q.col_ge1, 1'b0};
    end else begin
      cols = {1'b1, 1'b1, job_q.col_ge2};
    end
  end

  always_comb begin
    sum_d = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (rows[r] && cols[c]) begin
            sum_d[ch] = sum_d[ch] + SUM_W'(job_q.win[c*3 + r][ch*CH_W +: CH_W]);
          end
        end
      end
    end
    cnt_d = CNT_W'(CNT_W'($countones(rows)) * CNT_W'($countones(cols)));
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (prod_q[ch][PROD_W-1:RECIP_K] > NUM_W'(255)) begin
        quot[ch] = CH_W'(255);
      end else begin
        quot[ch] = prod_q[ch][RECIP_K +: CH_W];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = B_SUM;
        end
      end
      B_SUM: state_d = B_MUL;
      B_MUL: state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          state_d = (pend_q != '0) ? B_SUM : B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == B_SUM) begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      last_q <= ((pend_q & ~sel) == '0);
      done_q <= sel[KIND_LOW_END];
    end
    if (state_q == B_MUL) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= PROD_W'(({sum_q[ch], 1'b0} + NUM_W'(cnt_q)) * bbx_recip(cnt_q));
      end
    end
    if ((state_q == B_EMIT) && out_free) begin
      oval_q  <= quot;
      olast_q <= last_q;
      odone_q <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        pend_q <= job_i.kinds;
      end else if (state_q == B_SUM) begin
        pend_q <= pend_q & ~sel;
      end
      if ((state_q == B_EMIT) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.red_out    = oval_q[0];
  assign out_o.green_out  = oval_q[1];
  assign out_o.blue_out   = oval_q[2];
  assign out_o.run_last   = olast_q;
  assign out_o.frame_done = odone_q;

endmodule

// File: hw/rtl/box_blur_3x3_unit.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 unit
// Streaming 3x3 box blur over RGB raster frames with edge-aware averaging.
// ----------------------------------------------------------------------------
// Pixels enter on in_i in raster order; results leave on out_o, each with
// run_last on the last result of its input pixel and frame_done on the
// bottom-right pixel. Row r-1 is produced while row r streams in, and the
// last row is produced alongside it, so a pixel yields zero to four results.
// cfg_i writes frame_width (index 0) or frame_height (index 1); any such write
// restarts the frame. Write it only while no pixel is in flight.
// The front end cannot take a new pixel before it has written back the last,
// bounded by its single-port row store: it reads the two stored rows as it
// accepts a pixel and writes them back as it hands on the job, which waits
// while the queue is full. The back end fetches each job, then takes each
// result through a window sum, a reciprocal multiply and the output register,
// and a two-entry job queue lets both ends stall separately.
// Reset clears the frame position, the window and all valid state; the row
// stores need no clearing. When the receiver stalls, the output register
// holds its result, the queue fills and the input then stops accepting.
module box_blur_3x3_unit import bbx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbx_cfg_if.sink   cfg_i,
  bbx_in_if.sink    in_i,
  bbx_out_if.source out_o
);

  `include "box_blur_3x3_unit_defines.svh"

  logic       push;
  logic       pop;
  bbx_job_t   job_in;
  bbx_job_t   job_out;
  bbx_qstat_t qstat;

  bbx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (job_in)
  );

  bbx_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .qstat_o (qstat)
  );

  bbx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_out),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  `BBX_ASSERT_SAME(a_no_push_full, qstat.full, !push, "job pushed into a full queue")
  `BBX_ASSERT_SAME(a_no_pop_empty, qstat.empty, !pop, "job popped from an empty queue")
  `BBX_ASSERT_NEXT(a_push_lands, push, !qstat.empty, "pushed job missing from queue")
  `BBX_ASSERT_SAME(a_done_is_last, out_o.valid && out_o.frame_done, out_o.run_last,
                   "frame end not marked as last result of its pixel")

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 unit testbench
// Streams RGB pixels through the blur unit under several frame sizes and
// compares every result against an in-bench prediction of the 3x3 average,
// with random input bursts, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb import bbx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_FRAME_HEIGHT + 1'b1;

  typedef struct packed {
    bit [CH_W-1:0] red;
    bit [CH_W-1:0] green;
    bit [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    bit [CH_W-1:0] red;
    bit [CH_W-1:0] green;
    bit [CH_W-1:0] blue;
    bit            run_last;
    bit            frame_done;
  } blur_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bbx_cfg_if cfg_if ();
  bbx_in_if  pix_if ();
  bbx_out_if blur_if ();

  box_blur_3x3_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (pix_if),
    .out_o  (blur_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted state of the blur unit.
  logic [FW_W-1:0] blur_width  = FW_W'(1024);
  logic [FH_W-1:0] blur_height = FH_W'(768);
  rgb_t            older_rows[MAX_WIDTH];
  rgb_t            prior_rows[MAX_WIDTH];
  rgb_t            win_cols[9];
  int unsigned     row_pos = 0;
  int unsigned     col_pos = 0;

  rgb_t        pending_pixels[$];
  blur_res_t   blur_expected[$];
  rgb_t        pix_shown;
  blur_res_t   blur_head;
  int unsigned mismatches = 0;

  int unsigned gap_max = 0;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] ready_pattern = '1;
  logic [3:0]  ready_phase;
  int unsigned hold_requests = 0;
  int unsigned hold_served;
  int unsigned hold_left;

  function automatic blur_res_t window_average(bit [2:0] rows, bit [2:0] cols, bit done);
    blur_res_t   res;
    int unsigned sum_r, sum_g, sum_b, cnt;
    rgb_t        px;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    for (int col = 0; col < 3; col++) begin
      for (int row = 0; row < 3; row++) begin
        if (cols[col] && rows[row]) begin
          px = win_cols[col * 3 + row];
          sum_r += px.red;
          sum_g += px.green;
          sum_b += px.blue;
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.red = CH_W'((2 * sum_r + cnt) / (2 * cnt));
    res.green = CH_W'((2 * sum_g + cnt) / (2 * cnt));
    res.blue = CH_W'((2 * sum_b + cnt) / (2 * cnt));
    res.run_last = 1'b0;
    res.frame_done = done;
    return res;
  endfunction

  function automatic void predict_blur(rgb_t px);
    blur_res_t   outs[4];
    int unsigned w, h, c, r, slot, n, i;
    bit          last_row, row_end;
    bit [2:0]    mid_cols, end_cols, rows;
    w = (blur_width == 0) ? 1 : ((blur_width > MAX_WIDTH) ? MAX_WIDTH : blur_width);
    h = (blur_height == 0) ? 1 : blur_height;
    c = col_pos;
    r = row_pos;
    slot = c % MAX_WIDTH;
    n = 0;
    for (i = 0; i < 3; i++) begin
      win_cols[i] = win_cols[3 + i];
      win_cols[3 + i] = win_cols[6 + i];
    end
    win_cols[6] = older_rows[slot];
    win_cols[7] = prior_rows[slot];
    win_cols[8] = px;
    older_rows[slot] = prior_rows[slot];
    prior_rows[slot] = px;
    last_row = (r + 1 >= h);
    row_end = (c + 1 >= w);
    mid_cols = {2'b11, c >= 2};
    end_cols = {1'b1, c >= 1, 1'b0};
    if (r >= 1) begin
      rows = {2'b11, r >= 2};
      if (c >= 1) begin
        outs[n] = window_average(rows, mid_cols, 1'b0);
        n++;
      end
      if (row_end) begin
        outs[n] = window_average(rows, end_cols, 1'b0);
        n++;
      end
    end
    if (last_row) begin
      rows = {1'b1, r >= 1, 1'b0};
      if (c >= 1) begin
        outs[n] = window_average(rows, mid_cols, 1'b0);
        n++;
      end
      if (row_end) begin
        outs[n] = window_average(rows, end_cols, 1'b1);
        n++;
      end
    end
    if (n > 0) outs[n - 1].run_last = 1'b1;
    for (i = 0; i < n; i++) blur_expected.push_back(outs[i]);
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_FRAME_WIDTH) blur_width = value[FW_W-1:0];
    else if (idx == CFG_FRAME_HEIGHT) blur_height = value[FH_W-1:0];
    else return;
    row_pos = 0;
    col_pos = 0;
    foreach (win_cols[k]) win_cols[k] = '0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_config(idx, value);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix_if.valid || blur_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_pixel(bit [CH_W-1:0] red, bit [CH_W-1:0] green, bit [CH_W-1:0] blue);
    pending_pixels.push_back(rgb_t'({red, green, blue}));
  endtask

  task automatic pick_idling();
    if ($urandom_range(0, 3) == 0) begin
      gap_max = 0;
      ready_pattern = '1;
    end else begin
      gap_max = $urandom_range(1, 6);
      ready_pattern = 16'($urandom()) | 16'h0001;
    end
  endtask

  // Pixel driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.red_in <= '0;
      pix_if.green_in <= '0;
      pix_if.blue_in <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        predict_blur(pix_shown);
        if (burst_left == 0) begin
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          burst_left = $urandom_range(1, 12);
        end
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left == 0 && pending_pixels.size() != 0) begin
          pix_shown = pending_pixels.pop_front();
          if (burst_left > 0) burst_left--;
          pix_if.valid <= 1'b1;
          pix_if.red_in <= pix_shown.red;
          pix_if.green_in <= pix_shown.green;
          pix_if.blue_in <= pix_shown.blue;
        end else begin
          if (gap_left > 0) gap_left--;
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: rotating stall pattern, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_if.ready <= 1'b0;
      ready_phase = '0;
      hold_served = 0;
      hold_left = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        blur_if.ready <= 1'b0;
      end else begin
        blur_if.ready <= ready_pattern[ready_phase];
        ready_phase++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && blur_if.valid && blur_if.ready) begin
      if (blur_expected.size() == 0) begin
        $error("blurred pixel arrived with no expected result pending");
        mismatches++;
      end else begin
        blur_head = blur_expected.pop_front();
        check_field("red_out", blur_head.red, blur_if.red_out);
        check_field("green_out", blur_head.green, blur_if.green_out);
        check_field("blue_out", blur_head.blue, blur_if.blue_out);
        check_field("run_last", blur_head.run_last, blur_if.run_last);
        check_field("frame_done", blur_head.frame_done, blur_if.frame_done);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned rand_items, phase, n, w, h, i;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    pix_if.valid = 1'b0;
    pix_if.red_in = '0;
    pix_if.green_in = '0;
    pix_if.blue_in = '0;
    blur_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // At the reset frame size the first row gives no results.
    gap_max = 3;
    ready_pattern = 16'hB6DB;
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd128);
    push_pixel(8'd1, 8'd254, 8'd127);
    wait_idle();

    cfg_write(CFG_FRAME_WIDTH, 16'd1);
    cfg_write(CFG_FRAME_HEIGHT, 16'd1);
    push_pixel(8'd255, 8'd0, 8'd170);
    push_pixel(8'd0, 8'd255, 8'd85);
    push_pixel(8'd128, 8'd127, 8'd1);
    wait_idle();

    // Zero sizes behave as one.
    cfg_write(CFG_FRAME_WIDTH, 16'd0);
    cfg_write(CFG_FRAME_HEIGHT, 16'd0);
    push_pixel(8'd17, 8'd200, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    wait_idle();

    // Sums that land exactly on a half round up.
    cfg_write(CFG_FRAME_WIDTH, 16'd2);
    cfg_write(CFG_FRAME_HEIGHT, 16'd2);
    push_pixel(8'd0, 8'd255, 8'd1);
    push_pixel(8'd0, 8'd255, 8'd1);
    push_pixel(8'd0, 8'd255, 8'd1);
    push_pixel(8'd2, 8'd253, 8'd0);
    wait_idle();

    // A write to an unused index must neither take effect nor restart the frame.
    ready_pattern = '1;
    gap_max = 0;
    cfg_write(CFG_FRAME_WIDTH, 16'd3);
    cfg_write(CFG_FRAME_HEIGHT, 16'd3);
    for (i = 0; i < 4; i++) push_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255, 8'(i * 28));
    wait_idle();
    cfg_write(CFG_FIRST_UNUSED, 16'hFFFF);
    for (i = 4; i < 9; i++) push_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255, 8'(i * 28));
    wait_idle();

    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      pick_idling();
      if (phase == 2) begin
        n = 40;
        cfg_write(CFG_FRAME_WIDTH, $urandom_range(0, 1) ? 16'd1024 : 16'hFFFF);
        cfg_write(CFG_FRAME_HEIGHT, 16'd1);
      end else if (phase == 4) begin
        n = 40;
        cfg_write(CFG_FRAME_WIDTH, 16'($urandom_range(1, 2)));
        cfg_write(CFG_FRAME_HEIGHT, 16'hFFFF);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
        if (phase == 1) begin
          n = 80;
          gap_max = 0;
          hold_requests++;
        end
        if ($urandom_range(0, 4) != 0)
          cfg_write(CFG_FRAME_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
        if ($urandom_range(0, 4) != 0) cfg_write(CFG_FRAME_HEIGHT, 16'(h));
        if ($urandom_range(0, 5) == 0)
          cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)), 16'($urandom()));
      end
      rand_items += n;
      for (i = 0; i < n; i++) pending_pixels.push_back(rgb_t'(24'($urandom())));
      wait_idle();
      phase++;
    end

    if (mismatches == 0 && blur_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
